### sv/mra_pkg.sv
// ============================================================================
// mra_pkg: shared constants and types for the modular ring automaton
// Sizes of the cell ring, arithmetic widths, register indexes and the
// command/status bundles between the controller and the datapath.
// ============================================================================
package mra_pkg;

  // Ring geometry.
  localparam int CELLS      = 64;
  localparam int MAX_REPORT = 64;
  localparam int USED_MAX   = (CELLS < MAX_REPORT) ? CELLS : MAX_REPORT;
  localparam int IDX_W      = $clog2(CELLS);
  localparam int CNT_W      = $clog2(USED_MAX + 2);
  localparam int OUT_IDX_W  = 6;

  // Arithmetic widths.
  localparam int VAL_W      = 16;
  localparam int PROD_W     = 2 * VAL_W + 1;
  localparam int REM_BITS   = 4;
  localparam int REM_STEPS  = (PROD_W + REM_BITS - 1) / REM_BITS;
  localparam int DIV_W      = REM_STEPS * REM_BITS;
  localparam int REM_CNT_W  = $clog2(REM_STEPS);

  // Configuration registers.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int ACTIVE_W   = 7;
  localparam logic [CFG_ADDR_W-1:0] REG_MODULUS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE  = 1'b1;
  localparam logic [VAL_W-1:0]      MOD_RESET    = 16'd4;
  localparam logic [ACTIVE_W-1:0]   ACTIVE_RESET = 7'd64;

  // Stream widths.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic start;      // input beat accepted: latch count, rewind
    logic rd;         // read ring memory at the scan position
    logic cap;        // shift the read value into the window, emit report
    logic mul1;       // product a*(d+1)+1
    logic mul2;       // product b*x+a
    logic rem_start;  // start the remainder unit on the product
    logic wr;         // write the new cell value
    logic inc;        // advance the scan position
  } mra_cmd_t;

  typedef struct packed {
    logic k_lt_n;     // scan position is an active cell
    logic k_ge2;      // window is full, a cell can be updated
    logic k_last;     // final scan position of the tick
    logic out_free;   // output register can take a beat
    logic rem_done;   // remainder unit idle, result valid
  } mra_stat_t;

endpackage

### sv/mra_rem.sv
// ============================================================================
// mra_rem: multi-cycle remainder unit
// Restoring remainder of a product by the 16-bit modulus, four dividend
// bits per cycle. A zero modulus passes the low 16 bits through.
// ============================================================================
module mra_rem (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mra_pkg::PROD_W-1:0] dividend,
  input  logic [mra_pkg::VAL_W-1:0]  modulus,
  output logic                      busy,
  output logic [mra_pkg::VAL_W-1:0]  result
);
  import mra_pkg::*;

  logic [DIV_W-1:0]     shreg;
  logic [VAL_W-1:0]     rem;
  logic [VAL_W-1:0]     low;
  logic [REM_CNT_W-1:0] cnt;
  logic [VAL_W-1:0]     rem_next;

  always_comb begin
    logic [VAL_W:0] r17;
    rem_next = rem;
    for (int i = 0; i < REM_BITS; i++) begin
      r17 = {rem_next, shreg[DIV_W-1-i]};
      if (r17 >= {1'b0, modulus}) begin
        r17 = r17 - {1'b0, modulus};
      end
      rem_next = r17[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + REM_CNT_W'(1);
      if (cnt == REM_CNT_W'(REM_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= {{(DIV_W - PROD_W){1'b0}}, dividend};
      rem   <= '0;
      low   <= dividend[VAL_W-1:0];
    end else if (busy) begin
      shreg <= shreg << REM_BITS;
      rem   <= rem_next;
    end
  end

  assign result = (modulus == '0) ? low : rem;

endmodule

### sv/mra_dp.sv
// ============================================================================
// mra_dp: datapath of the modular ring automaton
// Configuration registers, cell ring memory with valid bits, neighbor
// window, the two multipliers, the remainder unit and the output register.
// ============================================================================
module mra_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  mra_pkg::mra_cmd_t             cmd,
  output mra_pkg::mra_stat_t            stat,
  input  logic                          restart,
  input  logic                          cfg_we,
  input  logic [mra_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mra_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mra_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                          m_tlast
);
  import mra_pkg::*;

  logic [VAL_W-1:0]     modulus;
  logic [ACTIVE_W-1:0]  active;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     k;
  logic [CNT_W-1:0]     n_clamped;
  logic [CELLS-1:0]     vld;
  logic [VAL_W-1:0]     mem [CELLS];
  logic [VAL_W-1:0]     rdata;
  logic                 rvld;
  logic [IDX_W-1:0]     raddr;
  logic [IDX_W-1:0]     waddr;
  logic [VAL_W-1:0]     mem_val;
  logic [VAL_W-1:0]     in_val;
  logic [VAL_W-1:0]     wa, wb, wd;
  logic [VAL_W-1:0]     saved0, saved1;
  logic [PROD_W-1:0]    prod;
  logic [VAL_W:0]       d_inc;
  logic [PROD_W-1:0]    mul1_p;
  logic [2*VAL_W-1:0]   mul2_m;
  logic [PROD_W-1:0]    mul2_s;
  logic                 rem_busy;
  logic [VAL_W-1:0]     rem_val;
  logic [OUT_IDX_W-1:0] out_idx;
  logic [VAL_W-1:0]     out_val;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
      active  <= ACTIVE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODULUS: modulus <= cfg_wdata[VAL_W-1:0];
        REG_ACTIVE:  active  <= cfg_wdata[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // An empty ring counts as one cell; an oversized one is clamped.
  always_comb begin
    if (active == '0) begin
      n_clamped = CNT_W'(1);
    end else if (active > ACTIVE_W'(USED_MAX)) begin
      n_clamped = CNT_W'(USED_MAX);
    end else begin
      n_clamped = CNT_W'(active);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= CNT_W'(1);
      k <= '0;
    end else if (cmd.start) begin
      n <= n_clamped;
      k <= '0;
    end else if (cmd.inc) begin
      k <= k + CNT_W'(1);
    end
  end

  assign raddr = k[IDX_W-1:0];
  assign waddr = IDX_W'(k - CNT_W'(2));

  // Valid bits: an unwritten entry reads as the seed value.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.start && restart) begin
      vld <= '0;
    end else if (cmd.wr) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[waddr] <= rem_val;
    end
    if (cmd.rd) begin
      rdata <= mem[raddr];
      rvld  <= vld[raddr];
    end
  end

  assign mem_val = rvld ? rdata : ((k == '0) ? VAL_W'(1) : '0);

  // Past the last active cell the window wraps onto the first two cells.
  always_comb begin
    if (stat.k_lt_n) begin
      in_val = mem_val;
    end else if (k == n) begin
      in_val = saved0;
    end else begin
      in_val = saved1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      wa <= wb;
      wb <= wd;
      wd <= in_val;
      if (k == '0) begin
        saved0 <= in_val;
        saved1 <= in_val;
      end else if (k == CNT_W'(1) && stat.k_lt_n) begin
        saved1 <= in_val;
      end
    end
  end

  assign d_inc  = {1'b0, wd} + (VAL_W + 1)'(1);
  assign mul1_p = {{(VAL_W + 1){1'b0}}, wa} * {{VAL_W{1'b0}}, d_inc};
  assign mul2_m = wb * rem_val;
  assign mul2_s = {1'b0, mul2_m} + {{(VAL_W + 1){1'b0}}, wa};

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod <= mul1_p + PROD_W'(1);
    end else if (cmd.mul2) begin
      prod <= mul2_s;
    end
  end

  mra_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.rem_start),
    .dividend (prod),
    .modulus  (modulus),
    .busy     (rem_busy),
    .result   (rem_val)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.cap && stat.k_lt_n) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap && stat.k_lt_n) begin
      out_idx <= k[OUT_IDX_W-1:0];
      out_val <= mem_val;
      m_tlast <= (k + CNT_W'(1)) == n;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - OUT_IDX_W - VAL_W){1'b0}}, out_val, out_idx};

  assign stat.k_lt_n   = k < n;
  assign stat.k_ge2    = k >= CNT_W'(2);
  assign stat.k_last   = k == (n + CNT_W'(1));
  assign stat.out_free = !m_tvalid || m_tready;
  assign stat.rem_done = !rem_busy;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.cap && stat.k_lt_n) |-> (!m_tvalid || m_tready))
    else $error("report beat overwrote a pending output beat");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> (stat.k_ge2 && (k <= n + CNT_W'(1))))
    else $error("cell write outside the active window");

  a_start_rewind: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (k == '0))
    else $error("scan position not rewound at tick start");

  a_rem_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.rem_start |-> stat.rem_done)
    else $error("remainder unit restarted while busy");

endmodule

### sv/mra_ctrl.sv
// ============================================================================
// mra_ctrl: sequencer of the modular ring automaton
// Walks the scan positions of one tick: read, window shift and report,
// then the two multiply/remainder passes and the write of each cell.
// ============================================================================
module mra_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  mra_pkg::mra_stat_t stat,
  output mra_pkg::mra_cmd_t  cmd
);
  import mra_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_CAP   = 4'd2;
  localparam logic [3:0] ST_MUL1  = 4'd3;
  localparam logic [3:0] ST_REM1  = 4'd4;
  localparam logic [3:0] ST_WAIT1 = 4'd5;
  localparam logic [3:0] ST_MUL2  = 4'd6;
  localparam logic [3:0] ST_REM2  = 4'd7;
  localparam logic [3:0] ST_WAIT2 = 4'd8;
  localparam logic [3:0] ST_WR    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_CAP;
      end
      ST_CAP: begin
        if (!stat.k_lt_n || stat.out_free) begin
          cmd.cap = 1'b1;
          if (stat.k_ge2) begin
            state_next = ST_MUL1;
          end else begin
            cmd.inc    = 1'b1;
            state_next = ST_RD;
          end
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_REM1;
      end
      ST_REM1: begin
        cmd.rem_start = 1'b1;
        state_next    = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (stat.rem_done) begin
          state_next = ST_MUL2;
        end
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_REM2;
      end
      ST_REM2: begin
        cmd.rem_start = 1'b1;
        state_next    = ST_WAIT2;
      end
      ST_WAIT2: begin
        if (stat.rem_done) begin
          state_next = ST_WR;
        end
      end
      ST_WR: begin
        cmd.wr  = 1'b1;
        cmd.inc = 1'b1;
        if (stat.k_last) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/modular_ring_automaton_step.sv
// ============================================================================
// modular_ring_automaton_step: ring of cells stepped by a modular rule
// One input beat is one tick: report every active cell, then update them.
// ============================================================================
// Each input beat is one tick. If its restart bit is set, the ring first
// returns to the seed state (cell 0 holds 1, all others 0). The tick then
// sends one output beat per active cell, in index order, carrying the cell
// index and its value before the update, with tlast on the final cell.
// Meanwhile every active cell is replaced by (a + b*(a*(d+1)+1)) mod
// modulus, where a, b and d are the old values of the cell and its next two
// neighbors, wrapping over the active count; a zero modulus keeps the low
// 16 bits. The next input beat is taken once the last cell is written. The
// tick time is set by the shared remainder unit, which handles four dividend
// bits per cycle and runs twice for each cell. Output beats leave through a
// register, so a slow sink stalls the scan only when a report finds that
// register still full. The ring lives in a single-port memory with per-cell
// valid bits, so reset and restart take effect at once, with no clearing
// pass. Configuration writes (index 0: modulus, index 1: active cell count,
// where zero means one and larger than 64 means 64) belong between ticks.
module modular_ring_automaton_step (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata fields, low bit up: restart[0], zero fill [7:1].
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mra_pkg::IN_DATA_W-1:0] s_tdata,
  // m_tdata fields, low bit up: cell_index[5:0], cell_value[21:6],
  // zero fill [23:22]. m_tlast carries last.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mra_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [mra_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mra_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mra_pkg::*;

  mra_cmd_t  cmd;
  mra_stat_t stat;

  // The controller only sequences; all values stay in the datapath.
  mra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The restart flag is sampled by the datapath on the accepting beat.
  mra_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .restart   (s_tdata[0]),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

### tb/modular_ring_automaton_step_tb.sv
// ============================================================================
// modular_ring_automaton_step_tb: self-checking bench for the ring automaton
// Ticks go in on the input stream. A scoreboard keeps its own copy of the
// ring, works out the cell reports that each accepted tick must produce,
// and checks the output beats against them in order. Both stream sides
// idle and stall at random.
// ============================================================================
module modular_ring_automaton_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mra_pkg::*;

  // Quiet time after the last report of a tick. The block may still be
  // writing the last cells when that report leaves, so registers are only
  // written after this pause.
  localparam int SETTLE_CYCLES = 400;
  localparam int RANDOM_TICKS  = 100;

  // One output beat as the block should send it.
  typedef struct {
    bit [OUT_IDX_W-1:0] index;
    bit [VAL_W-1:0]     value;
    bit                 last_flag;
  } cell_report_t;

  // The scoreboard holds its own ring, modulus and active count. Each noted
  // tick reports the old values of the active cells and then computes the
  // next generation from them.
  class ring_scoreboard;
    bit [VAL_W-1:0]    ring [CELLS];
    bit [VAL_W-1:0]    modulus;
    bit [ACTIVE_W-1:0] active_cells;
    cell_report_t      expected_reports [$];
    int                errors;

    function void load_seed();
      foreach (ring[i]) ring[i] = '0;
      ring[0] = 1;
    endfunction

    function void reset_state();
      load_seed();
      modulus      = MOD_RESET;
      active_cells = ACTIVE_RESET;
      errors       = 0;
      expected_reports.delete();
    endfunction

    function void set_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr == REG_MODULUS) modulus = data[VAL_W-1:0];
      else if (addr == REG_ACTIVE) active_cells = data[ACTIVE_W-1:0];
    endfunction

    // A count of zero means one cell; anything above the ring size is clamped.
    function int used_cells();
      int n;
      n = active_cells;
      if (n == 0) n = 1;
      if (n > USED_MAX) n = USED_MAX;
      return n;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void note_tick(bit restart);
      bit [VAL_W-1:0] old [CELLS];
      bit [63:0]      a, b, d, v;
      int             n;
      cell_report_t   r;
      if (restart) load_seed();
      n   = used_cells();
      old = ring;
      for (int c = 0; c < n; c++) begin
        a = old[c];
        b = old[(c + 1) % n];
        d = old[(c + 2) % n];
        // Exact below 2^49; a zero modulus leaves only the 16-bit truncation.
        v = a + b * (a * (d + 1) + 1);
        if (modulus != 0) v = v % modulus;
        ring[c]     = v[VAL_W-1:0];
        r.index     = OUT_IDX_W'(c);
        r.value     = a[VAL_W-1:0];
        r.last_flag = (c == n - 1);
        expected_reports.push_back(r);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("tb: mismatch at %0t: %s", $time, msg);
    endtask

    task check_beat(bit [OUT_IDX_W-1:0] index, bit [VAL_W-1:0] value, bit last_flag);
      cell_report_t want;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected beat index %0d value %0d last %0b",
                                  index, value, last_flag));
        return;
      end
      want = expected_reports.pop_front();
      if (index != want.index)
        report_mismatch($sformatf("cell index %0d, want %0d", index, want.index));
      if (value != want.value)
        report_mismatch($sformatf("cell %0d value %0d, want %0d", want.index, value,
                                  want.value));
      if (last_flag != want.last_flag)
        report_mismatch($sformatf("cell %0d last %0b, want %0b", want.index, last_flag,
                                  want.last_flag));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;   // restart[0], zero fill [7:1]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;   // cell_index[5:0], cell_value[21:6], fill [23:22]
  logic                   m_tlast;   // last
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // When set, neither side idles, so beats run back to back.
  bit quiet;

  ring_scoreboard sb = new();

  modular_ring_automaton_step dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle gap before a beat: none half of the time, else a random nonzero one.
  function automatic int draw_gap();
    if (quiet) return 0;
    return ($urandom_range(0, 1) != 0) ? $urandom_range(1, 16) : 0;
  endfunction

  // Offers one tick and returns at the rising edge that accepts it, with
  // tvalid still high so that a following tick can go out back to back.
  task automatic send_tick(bit restart);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = IN_DATA_W'(restart);
    s_tvalid = 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_tick(restart);
  endtask

  // Drops tvalid before the next rising edge so the held tick is not taken twice.
  task automatic finish_burst();
    @(negedge clk);
    s_tvalid = 1'b0;
    s_tdata  = '0;
  endtask

  task automatic directed_burst(int count, bit [7:0] restarts);
    for (int i = 0; i < count; i++) send_tick(restarts[i]);
    finish_burst();
  endtask

  // Waits until every expected report has come, then lets the block finish
  // its last cell writes.
  task automatic wait_quiescent();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    sb.set_register(addr, data);
  endtask

  // The active count sits in the low seven bits; the bits above it are
  // filled at random since the block is to ignore them.
  task automatic configure(int modulus, int active);
    logic [CFG_DATA_W-1:0] act_word;
    wait_quiescent();
    act_word = (CFG_DATA_W'($urandom_range(0, 511)) << ACTIVE_W) |
               CFG_DATA_W'(active & 'h7F);
    write_register(REG_MODULUS, CFG_DATA_W'(modulus));
    write_register(REG_ACTIVE, act_word);
  endtask

  // Output side: a random stall before each beat, then take it at the
  // rising edge where tvalid is high and check it.
  initial begin : sink_side
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      sb.check_beat(m_tdata[5:0], m_tdata[21:6], m_tlast);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int random_ticks;
    int burst;
    int mod_pick;
    int act_pick;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    quiet     = 1'b0;
    random_ticks = 0;
    sb.reset_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: full ring of 64, modulus 4. The first tick must report
    // the seed. A restart on the third tick brings the seed back.
    directed_burst(3, 8'b100);

    // Zero modulus means no reduction, and a zero count means one cell, which
    // is then its own neighbor on both sides. The values grow quickly here.
    quiet = 1'b1;
    configure(0, 0);
    directed_burst(3, 8'b001);

    // Modulus one: the seed still reports as 1 before being reduced to 0.
    configure(1, 1);
    directed_burst(2, 8'b01);

    // A count above the ring size is clamped to 64; largest modulus.
    quiet = 1'b0;
    configure(65535, 127);
    directed_burst(3, 8'b001);

    // Shrink the ring: the cells beyond the count keep their values.
    configure(0, 3);
    directed_burst(3, 8'b000);
    configure(65535, 2);
    directed_burst(2, 8'b00);

    // Grow it again: the kept cells come back into use unchanged.
    configure(2, 64);
    directed_burst(1, 8'b0);
    configure(65534, 65);
    directed_burst(1, 8'b0);

    // Random phases: mostly small rings, now and then a full or clamped one,
    // moduli drawn from the extremes and from the whole range.
    while (random_ticks < RANDOM_TICKS) begin
      case ($urandom_range(0, 5))
        0:       mod_pick = 0;
        1:       mod_pick = 1;
        2:       mod_pick = 65535;
        3:       mod_pick = $urandom_range(2, 16);
        default: mod_pick = $urandom_range(1, 65535);
      endcase
      case ($urandom_range(0, 9))
        0:       act_pick = 64;
        1:       act_pick = $urandom_range(65, 127);
        2:       act_pick = 0;
        default: act_pick = $urandom_range(1, 8);
      endcase
      configure(mod_pick, act_pick);
      quiet = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(3, 10);
      repeat (burst) begin
        send_tick($urandom_range(0, 4) == 0);
        random_ticks++;
      end
      finish_burst();
    end

    wait_quiescent();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // The time limit leaves several times the slowest correct run.
  initial begin : watchdog
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
